FILE: src/sha_pkg.sv
`timescale 1ns / 1ps

package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
        ror32 = (v >> s) | (v << (32 - s));
    endfunction

endpackage

FILE: src/sha_ram.sv
`timescale 1ns / 1ps

module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/sha256_stream_hash_core.sv
`timescale 1ns / 1ps

// Streaming SHA-256 engine. One message byte is taken per word on the input
// channel and packed into a 16-entry block RAM by read-modify-write: the
// target word is read, then written back with the byte merged in. The 64th byte
// of a block starts a compression that walks the 16-entry schedule RAM round by
// round. Each of the first 16 rounds makes two reads and then the round update,
// and each later round makes four reads of the schedule window, then the update
// with the write-back of the new schedule word. Loading and updating the
// chaining words are one state each, and input is stalled for the whole block.
// An end-of-message word pads the block (one RAM write per
// remaining word), runs one or two compressions and then presents eight
// digest words, H0 first, the last one flagged.
module sha256_stream_hash_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sha_pkg::sha_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output sha_pkg::sha_out_t out_data
);

    import sha_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BYTE  = 4'd1;
    localparam logic [3:0] S_PAD   = 4'd2;
    localparam logic [3:0] S_LEN   = 4'd3;
    localparam logic [3:0] S_CLOAD = 4'd4;
    localparam logic [3:0] S_RRD   = 4'd5;
    localparam logic [3:0] S_RWR   = 4'd6;
    localparam logic [3:0] S_CUPD  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [7:0]  byte_reg, byte_next;
    logic        end_reg, end_next;
    logic        after_reg, after_next;   // 0: compress during finish, followed by the length block or the digest
    logic [3:0]  widx_reg, widx_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  hidx_reg, hidx_next;
    logic        two_reg, two_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next, f_next, g_next, h_next;
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];

    logic        bw_we;
    logic [3:0]  bw_wa, bw_ra;
    logic [31:0] bw_wd, bw_rd;

    sha_ram #(.WIDTH(32), .DEPTH(16)) u_block (
        .clk(clk), .we(bw_we), .waddr(bw_wa), .wdata(bw_wd), .raddr(bw_ra), .rdata(bw_rd)
    );

    // The schedule lives in the block RAM itself: w[t] replaces w[t-16] at
    // entry t mod 16. Each later round reads w[t-16], w[t-15], w[t-7], w[t-2] one per
    // cycle, so the round needs several reads; a simple sequencer walks them.
    logic [1:0]  sub_reg, sub_next;
    logic [31:0] x15_reg, x15_next, x7_reg, x7_next, x16_reg, x16_next;

    logic [31:0] s0, s1, wnew, wuse, t1, t2, big0, big1, ch, maj;

    always_comb
    begin
        s0   = ror32(x15_reg, 7) ^ ror32(x15_reg, 18) ^ (x15_reg >> 3);
        s1   = ror32(bw_rd, 17) ^ ror32(bw_rd, 19) ^ (bw_rd >> 10);
        wnew = x16_reg + s0 + x7_reg + s1;
        wuse = (rnd_reg < 6'd16) ? x16_reg : wnew;
        big1 = ror32(e_reg, 6) ^ ror32(e_reg, 11) ^ ror32(e_reg, 25);
        ch   = (e_reg & f_reg) ^ (~e_reg & g_reg);
        t1   = h_reg + big1 + ch + ROUND_K[rnd_reg] + wuse;
        big0 = ror32(a_reg, 2) ^ ror32(a_reg, 13) ^ ror32(a_reg, 22);
        maj  = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
        t2   = big0 + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        after_next = after_reg;
        widx_next  = widx_reg;
        rnd_next   = rnd_reg;
        hidx_next  = hidx_reg;
        two_next   = two_reg;
        sub_next   = sub_reg;
        x15_next   = x15_reg;
        x7_next    = x7_reg;
        x16_next   = x16_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        e_next = e_reg; f_next = f_reg; g_next = g_reg; h_next = h_reg;
        for (int i = 0; i < 8; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        bw_we = 1'b0;
        bw_wa = fill_reg[5:2];
        bw_wd = 32'd0;
        bw_ra = fill_reg[5:2];
        in_stall  = (state_reg != S_IDLE);
        out_valid = (state_reg == S_EMIT);
        out_data.digest_word = chain_reg[hidx_reg];
        out_data.word_index  = hidx_reg;
        out_data.last_word   = (hidx_reg == 3'd7);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = in_data.data_byte;
                    end_next  = in_data.message_end;
                    if (in_data.byte_present)
                    begin
                        state_next = S_BYTE;   // RAM read of the target word issued now
                    end
                    else if (in_data.message_end)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_BYTE:
            begin
                bw_we = 1'b1;
                case (fill_reg[1:0])
                    2'd0:    bw_wd = {byte_reg, 24'd0};
                    2'd1:    bw_wd = {bw_rd[31:24], byte_reg, 16'd0};
                    2'd2:    bw_wd = {bw_rd[31:16], byte_reg, 8'd0};
                    default: bw_wd = {bw_rd[31:8], byte_reg};
                endcase
                bits_next = bits_reg + 64'd8;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63)
                begin
                    after_next = 1'b1;
                    state_next = S_CLOAD;
                    hidx_next  = 3'd0;
                end
                else
                begin
                    state_next = end_reg ? S_PAD : S_IDLE;
                end
            end
            S_PAD:
            begin
                // pad byte at fill position, then zero the rest word by word
                if (sub_reg == 2'd0)
                begin
                    sub_next = 2'd1;   // wait for read of the partial word
                end
                else
                begin
                    bw_we = 1'b1;
                    case (fill_reg[1:0])
                        2'd0:    bw_wd = {PAD_BYTE, 24'd0};
                        2'd1:    bw_wd = {bw_rd[31:24], PAD_BYTE, 16'd0};
                        2'd2:    bw_wd = {bw_rd[31:16], PAD_BYTE, 8'd0};
                        default: bw_wd = {bw_rd[31:8], PAD_BYTE};
                    endcase
                    sub_next   = 2'd0;
                    widx_next  = fill_reg[5:2] + 4'd1;
                    two_next   = (fill_reg >= 6'd56);
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                // zero fill, then length in words 14 and 15 unless two blocks
                bw_we = 1'b1;
                bw_wa = widx_reg;
                if (!two_reg && widx_reg == 4'd14)
                begin
                    bw_wd = bits_reg[63:32];
                end
                else if (!two_reg && widx_reg == 4'd15)
                begin
                    bw_wd = bits_reg[31:0];
                end
                else
                begin
                    bw_wd = 32'd0;
                end
                if (widx_reg == 4'd15 || (widx_reg == 4'd0 && fill_reg[5:2] == 4'd15))
                begin
                    bw_we      = (widx_reg == 4'd15);
                    after_next = 1'b0;
                    hidx_next  = 3'd0;
                    state_next = S_CLOAD;
                end
                widx_next = widx_reg + 4'd1;
            end
            S_CLOAD:
            begin
                a_next = chain_reg[0]; b_next = chain_reg[1];
                c_next = chain_reg[2]; d_next = chain_reg[3];
                e_next = chain_reg[4]; f_next = chain_reg[5];
                g_next = chain_reg[6]; h_next = chain_reg[7];
                rnd_next   = 6'd0;
                sub_next   = 2'd0;
                bw_ra      = 4'd0;
                state_next = S_RRD;
            end
            S_RRD:
            begin
                // sub 0: issue w[t-16]; 1: w[t-15]; 2: w[t-7]; 3: w[t-2]
                case (sub_reg)
                    2'd0:    bw_ra = rnd_reg[3:0];
                    2'd1:    bw_ra = rnd_reg[3:0] + 4'd1;
                    2'd2:    bw_ra = rnd_reg[3:0] + 4'd9;
                    default: bw_ra = rnd_reg[3:0] + 4'd14;
                endcase
                case (sub_reg)
                    2'd1:    x16_next = bw_rd;
                    2'd2:    x15_next = bw_rd;
                    2'd3:    x7_next  = bw_rd;
                    default: x16_next = x16_reg;
                endcase
                if (sub_reg == 2'd3 || rnd_reg < 6'd16 && sub_reg == 2'd1)
                begin
                    state_next = S_RWR;
                end
                sub_next = sub_reg + 2'd1;
            end
            S_RWR:
            begin
                if (rnd_reg >= 6'd16)
                begin
                    bw_we = 1'b1;
                    bw_wa = rnd_reg[3:0];
                    bw_wd = wnew;
                end
                else
                begin
                    x16_next = bw_rd;
                end
                h_next = g_reg; g_next = f_reg; f_next = e_reg; e_next = d_reg + t1;
                d_next = c_reg; c_next = b_reg; b_next = a_reg; a_next = t1 + t2;
                sub_next = 2'd0;
                rnd_next = rnd_reg + 6'd1;
                state_next = (rnd_reg == 6'd63) ? S_CUPD : S_RRD;
            end
            S_CUPD:
            begin
                chain_next[0] = chain_reg[0] + a_reg; chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg; chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg; chain_next[5] = chain_reg[5] + f_reg;
                chain_next[6] = chain_reg[6] + g_reg; chain_next[7] = chain_reg[7] + h_reg;
                if (after_reg)
                begin
                    state_next = end_reg ? S_PAD : S_IDLE;
                end
                else if (two_reg)
                begin
                    two_next   = 1'b0;
                    widx_next  = 4'd0;
                    fill_next  = 6'd0;    // next LEN pass rewrites all sixteen words
                    state_next = S_LEN;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_stall)
                begin
                    hidx_next = hidx_reg + 3'd1;
                    if (hidx_reg == 3'd7)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = START_H[i];
                end
                fill_next  = 6'd0;
                bits_next  = 64'd0;
                end_next   = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Round reads: sub counts issue order; rdata is registered and arrives in the next
    // cycle, so the value captured at sub k belongs to the read issued at sub k-1.
    // In RWR the last read (w[t-2], or w[t+1] for early rounds) is on bw_rd.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= 6'd0;
            bits_reg  <= 64'd0;
            end_reg   <= 1'b0;
            after_reg <= 1'b0;
            two_reg   <= 1'b0;
            sub_reg   <= 2'd0;
            hidx_reg  <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= START_H[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            end_reg   <= end_next;
            after_reg <= after_next;
            two_reg   <= two_next;
            sub_reg   <= sub_next;
            hidx_reg  <= hidx_next;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        widx_reg <= widx_next;
        rnd_reg  <= rnd_next;
        x15_reg  <= x15_next;
        x7_reg   <= x7_next;
        x16_reg  <= x16_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
        e_reg <= e_next; f_reg <= f_next; g_reg <= g_next; h_reg <= h_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while digest is shown");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.last_word) |=> (state_reg == S_FIN))
        else $error("last word did not finish the message");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> (fill_reg == 6'd0 && bits_reg == 64'd0))
        else $error("message state not cleared");

endmodule

FILE: tb/sha256_stream_hash_core_test.sv
`timescale 1ns / 1ps

module sha256_stream_hash_core_test;
    import sha_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_CYCLES = 1500;

    typedef struct {
        sha_in_t item;
        bit      drain_first;
    } pending_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    sha_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    sha_out_t out_data;

    sha256_stream_hash_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    pending_t send_q[$];
    sha_out_t digest_q[$];

    // Hash state of the predictor.
    logic [31:0] chain[8];
    logic [31:0] blk[16];
    logic [5:0]  fill;
    logic [63:0] msg_bits;

    int  errors = 0;
    int  words_in = 0;
    int  words_out = 0;
    int  messages = 0;
    int  idle_cycles = 0;
    bit  in_fire = 0;
    int  gap_left = 0;
    int  burst_left = 4;
    int  stall_mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 0;

    initial clk = 0;
    always #5 clk = ~clk;

    function automatic logic [31:0] rotr(logic [31:0] v, int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    function automatic void compress();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = blk[t];
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function automatic void put_byte(logic [7:0] v);
        int sh;
        sh = 24 - 8 * fill[1:0];
        if (fill[1:0] == 0)
            blk[fill[5:2]] = 32'(v) << sh;
        else
            blk[fill[5:2]] |= 32'(v) << sh;
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 8; i++)
            chain[i] = START_H[i];
        fill = 0;
        msg_bits = 0;
    endfunction

    function automatic void hash_word(sha_in_t w);
        sha_out_t r;
        if (w.byte_present)
        begin
            put_byte(w.data_byte);
            msg_bits += 8;
            fill = fill + 1;
            if (fill == 0)
                compress();
        end
        if (w.message_end)
        begin
            int pos;
            pos = fill;
            put_byte(PAD_BYTE);
            for (int k = pos / 4 + 1; k < 16; k++)
                blk[k] = 0;
            if (pos >= 56)
            begin
                compress();
                for (int k = 0; k < 16; k++)
                    blk[k] = 0;
            end
            blk[14] = msg_bits[63:32];
            blk[15] = msg_bits[31:0];
            compress();
            for (int k = 0; k < 8; k++)
            begin
                r.digest_word = chain[k];
                r.word_index = 3'(k);
                r.last_word = (k == 7);
                digest_q = {digest_q, r};
            end
            messages++;
            hash_restart();
        end
    endfunction

    function automatic void add_item(logic [7:0] v, bit present, bit fin, bit drain);
        pending_t p;
        p.item.data_byte = v;
        p.item.byte_present = present;
        p.item.message_end = fin;
        p.drain_first = drain;
        send_q = {send_q, p};
    endfunction

    // A message of len bytes; the end rides on the last byte or comes alone.
    function automatic int add_message(int len, bit drain);
        bit joined;
        int n;
        n = 0;
        joined = (len > 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_item(8'($urandom), 0, 0, 0);
                n++;
            end
            add_item(8'($urandom), 1, joined && (i == len - 1), drain && (i == 0));
            n++;
        end
        if (!joined)
        begin
            add_item(8'($urandom), 0, 1, drain && (len == 0));
            n++;
        end
        return n;
    endfunction

    initial
    begin
        int count;
        int len;
        int pick;
        count = 0;
        // Empty message, single extreme bytes, a short string and an idle word.
        add_item(8'h00, 0, 1, 0);
        add_item(8'h00, 1, 1, 0);
        add_item(8'hff, 1, 0, 0);
        add_item(8'hff, 0, 1, 0);
        add_item(8'ha5, 0, 0, 0);
        add_item(8'h61, 1, 0, 1);
        add_item(8'h62, 1, 0, 0);
        add_item(8'h63, 1, 0, 0);
        add_item(8'h5a, 0, 1, 0);
        while (count < 360)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                len = $urandom_range(20);
            else if (pick < 90)
                len = $urandom_range(70, 50);
            else
                len = $urandom_range(140, 100);
            if (len > 360 - count)
                len = 360 - count;
            count += add_message(len, $urandom_range(7) == 0);
        end
    end

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        hash_restart();
        repeat (7) @(negedge clk);
        rst_n = 1;
    end

    // Sender: bursts of words with random gaps; some words wait for a drain.
    always @(negedge clk)
    begin
        pending_t nxt;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 0;
                gap_left <= gap_left - 1;
            end
            else if (send_q.size() > 0 && !(send_q[0].drain_first && digest_q.size() > 0))
            begin
                nxt = send_q.pop_front();
                in_valid <= 1;
                in_data <= nxt.item;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(30, 1);
                    gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 0;
        end
    end

    // Receiver: stall pattern changes every so often; one long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && hold_left == 0 && words_out >= 40)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1;
                out_stall <= 1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= (hold_left > 1);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(2);
                    mode_left <= $urandom_range(80, 10);
                end
                else
                    mode_left <= mode_left - 1;
                case (stall_mode)
                    0: out_stall <= 0;
                    1: out_stall <= ($urandom_range(3) == 0);
                    default: out_stall <= ($urandom_range(3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        sha_out_t want;
        in_fire = in_valid && !in_stall;
        if (in_fire)
        begin
            words_in++;
            hash_word(in_data);
        end
        if (out_valid && !out_stall)
        begin
            words_out++;
            if (digest_q.size() == 0)
            begin
                $error("digest word with none expected: %h", out_data.digest_word);
                errors++;
            end
            else
            begin
                want = digest_q.pop_front();
                if (out_data.digest_word !== want.digest_word)
                begin
                    $error("digest_word expected %h got %h", want.digest_word,
                           out_data.digest_word);
                    errors++;
                end
                if (out_data.word_index !== want.word_index)
                begin
                    $error("word_index expected %0d got %0d", want.word_index,
                           out_data.word_index);
                    errors++;
                end
                if (out_data.last_word !== want.last_word)
                begin
                    $error("last_word expected %0d got %0d", want.last_word,
                           out_data.last_word);
                    errors++;
                end
            end
        end
        if (in_fire || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d digest words outstanding", digest_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (send_q.size() > 0 || in_valid || digest_q.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        $display("%0d input words hashed into %0d messages, %0d digest words compared",
                 words_in, messages, words_out);
        if (errors == 0 && digest_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/sha_pkg.sv
src/sha_ram.sv
src/sha256_stream_hash_core.sv
tb/sha256_stream_hash_core_test.sv
